/* rtl/vfsm_pkg.sv */
`timescale 1ns / 1ps
package vfsm_pkg;

  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned ADDR_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = ADDR_W + 1;

  localparam logic [2:0] REG_FAT16_MODE = 3'd0;
  localparam logic [2:0] REG_MBR_ENABLE = 3'd1;
  localparam logic [2:0] REG_SECTORS_PER_FAT = 3'd2;
  localparam logic [2:0] REG_TOTAL_SECTORS = 3'd3;
  localparam logic [2:0] REG_VOLUME_SERIAL = 3'd4;
  localparam logic [2:0] REG_BOUNDARY_COUNT = 3'd5;

  localparam logic [2:0] RGN_MBR = 3'd0;
  localparam logic [2:0] RGN_FAT = 3'd1;
  localparam logic [2:0] RGN_ZERO = 3'd2;
  localparam logic [2:0] RGN_RESERVED = 3'd3;
  localparam logic [2:0] RGN_ROOT = 3'd4;
  localparam logic [2:0] RGN_FILE = 3'd5;

  localparam logic [31:0] EOC32 = 32'h0FFF_FFFF;
  localparam logic [15:0] EOC16 = 16'hFFFF;
  localparam logic [7:0] MEDIA_BYTE = 8'hF8;
  localparam logic [7:0] BOOT_FLAG = 8'h80;
  localparam logic [31:0] CHS_START = 32'd9 << 10;
  localparam logic [7:0] PART_FAT16 = 8'h0E;
  localparam logic [7:0] PART_FAT32 = 8'h0C;
  localparam logic [7:0] SIG_LO = 8'h55;
  localparam logic [7:0] SIG_HI = 8'hAA;
  localparam logic [5:0] W_SERIAL = 6'd55;
  localparam logic [5:0] W_PART_A = 6'd56;
  localparam logic [5:0] W_PART_B = 6'd57;
  localparam logic [5:0] W_SIG = 6'd63;

  typedef enum logic [3:0] {
    S_IDLE, S_MBR, S_RES, S_FATD, S_ROOT, S_FLIM, S_FLIMW, S_FSCAN, S_EMIT,
    S_DKEY, S_DSCAN, S_DIDX, S_DIDXW, S_DESC
  } state_t;

endpackage

/* rtl/virtual_fat_sector_mapper_core.sv */
`timescale 1ns / 1ps
// Maps sector reads of a virtual FAT16/FAT32 volume. A load transfer writes one
// boundary into the table. Reads are handled one at a time, and the input
// stalls until the last result of the current read has gone into the output register.
// A read of a data sector scans the table memory one entry per cycle over all
// valid boundaries. The MBR sector emits 64 words at one per cycle while the output
// does not stall; a FAT sector first reads the last boundary and scans the whole
// table, then emits its 64 words.
module virtual_fat_sector_mapper_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [31:0] in_lba,
  input  logic [9:0]  in_entry_index,
  input  logic [31:0] in_entry_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_region,
  output logic [63:0] out_data_word,
  output logic [10:0] out_file_index,
  output logic [31:0] out_sector_in_region,
  output logic        out_last
);

  vfsm_pkg::state_t state_r, state_nxt;

  logic        fat16_r, mbr_en_r;
  logic [15:0] spf_r;
  logic [31:0] total_r, serial_r;
  logic [10:0] bcount_r;

  logic [31:0] bt_mem [vfsm_pkg::MAX_ENTRIES];
  logic [31:0] mem_q_r;
  logic [vfsm_pkg::ADDR_W-1:0] rd_addr;
  logic        q_vld_r;

  logic [31:0] off_r, start_r, start_p1_r, limit_r, key_r;
  logic [vfsm_pkg::CNT_W-1:0] i_r, cnt_r, n_c, files_c;
  logic [255:0] bmp_r;
  logic [5:0]  w_r;
  logic [2:0]  gen_rgn_r, desc_rgn_r;
  logic [31:0] desc_sec_r;
  logic [10:0] desc_fi_r;

  logic        out_valid_r, out_last_r;
  logic [2:0]  out_region_r;
  logic [63:0] out_data_r;
  logic [10:0] out_fi_r;
  logic [31:0] out_sec_r;

  logic        out_free, out_load, in_acc, scan_done;
  logic [16:0] fat2_c;
  logic [8:0]  per_c;
  logic [63:0] word_c, mbr_word_c, fat_word_c;
  logic [31:0] dist_c;

  assign n_c = (bcount_r > 11'(vfsm_pkg::MAX_ENTRIES)) ?
               vfsm_pkg::CNT_W'(vfsm_pkg::MAX_ENTRIES) : vfsm_pkg::CNT_W'(bcount_r);
  assign files_c = fat16_r ? n_c : ((n_c != '0) ? n_c - 1'b1 : '0);
  assign fat2_c = {spf_r, 1'b0};
  assign per_c = fat16_r ? 9'd256 : 9'd128;
  assign out_free = !out_valid_r || !out_stall;
  assign in_acc = in_valid && !in_stall;
  assign scan_done = (i_r == n_c) && !q_vld_r;
  assign dist_c = mem_q_r - start_p1_r;

  always_comb begin
    mbr_word_c = '0;
    case (w_r)
      vfsm_pkg::W_SERIAL: mbr_word_c = {8'h00, vfsm_pkg::BOOT_FLAG, 16'h0000, serial_r};
      vfsm_pkg::W_PART_A: mbr_word_c = {8'h00, 8'h08, 8'hFF, 8'hFF, 8'hFE,
                                        fat16_r ? vfsm_pkg::PART_FAT16 : vfsm_pkg::PART_FAT32,
                                        vfsm_pkg::CHS_START[15:0]};
      vfsm_pkg::W_PART_B: mbr_word_c = {16'h0000, total_r - 32'd8, 16'h0000};
      vfsm_pkg::W_SIG: mbr_word_c = {vfsm_pkg::SIG_HI, vfsm_pkg::SIG_LO, 48'h0};
      default: mbr_word_c = '0;
    endcase
  end

  always_comb begin
    logic [7:0]  idx;
    logic [31:0] c;
    logic [31:0] lk;
    fat_word_c = '0;
    for (int k = 0; k < 4; k++) begin
      if (fat16_r) begin
        idx = {w_r, 2'(k)};
      end else begin
        idx = {1'b0, w_r, 1'(k)};
      end
      c = start_r + 32'(idx);
      if (c >= limit_r) begin
        lk = '0;
      end else if (bmp_r[idx]) begin
        lk = fat16_r ? 32'(vfsm_pkg::EOC16) : vfsm_pkg::EOC32;
      end else begin
        lk = c + 32'd1;
      end
      if (fat16_r) begin
        fat_word_c[16*k +: 16] = lk[15:0];
      end else if (k < 2) begin
        fat_word_c[32*k +: 32] = lk;
      end
    end
    if (off_r == '0 && w_r == '0) begin
      fat_word_c[31:0] = {24'hFFFFFF, vfsm_pkg::MEDIA_BYTE};
      if (!fat16_r) begin
        fat_word_c[63:32] = 32'hFFFF_FFFF;
      end
    end
  end

  assign word_c = (gen_rgn_r == vfsm_pkg::RGN_MBR) ? mbr_word_c : fat_word_c;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vfsm_pkg::S_IDLE: if (in_acc && in_func) state_nxt = vfsm_pkg::S_MBR;
      vfsm_pkg::S_MBR: begin
        if (mbr_en_r && off_r < 32'd8) begin
          state_nxt = (off_r != '0) ? vfsm_pkg::S_DESC : vfsm_pkg::S_EMIT;
        end else begin
          state_nxt = vfsm_pkg::S_RES;
        end
      end
      vfsm_pkg::S_RES: begin
        if (off_r < (fat16_r ? 32'd1 : 32'd16)) state_nxt = vfsm_pkg::S_DESC;
        else state_nxt = vfsm_pkg::S_FATD;
      end
      vfsm_pkg::S_FATD: begin
        if (off_r < 32'(fat2_c)) state_nxt = vfsm_pkg::S_FLIM;
        else state_nxt = fat16_r ? vfsm_pkg::S_ROOT : vfsm_pkg::S_DKEY;
      end
      vfsm_pkg::S_ROOT: state_nxt = (off_r < 32'd32) ? vfsm_pkg::S_DESC : vfsm_pkg::S_DKEY;
      vfsm_pkg::S_FLIM: state_nxt = vfsm_pkg::S_FLIMW;
      vfsm_pkg::S_FLIMW: state_nxt = vfsm_pkg::S_FSCAN;
      vfsm_pkg::S_FSCAN: if (scan_done) state_nxt = vfsm_pkg::S_EMIT;
      vfsm_pkg::S_EMIT: if (out_free && w_r == 6'd63) state_nxt = vfsm_pkg::S_IDLE;
      vfsm_pkg::S_DKEY: state_nxt = vfsm_pkg::S_DSCAN;
      vfsm_pkg::S_DSCAN: begin
        if (scan_done) begin
          state_nxt = (cnt_r < n_c && cnt_r != '0) ? vfsm_pkg::S_DIDX : vfsm_pkg::S_DESC;
        end
      end
      vfsm_pkg::S_DIDX: state_nxt = vfsm_pkg::S_DIDXW;
      vfsm_pkg::S_DIDXW: state_nxt = vfsm_pkg::S_DESC;
      vfsm_pkg::S_DESC: if (out_free) state_nxt = vfsm_pkg::S_IDLE;
      default: state_nxt = vfsm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != vfsm_pkg::S_IDLE);
    out_load = out_free && (state_r == vfsm_pkg::S_EMIT || state_r == vfsm_pkg::S_DESC);
    case (state_r)
      vfsm_pkg::S_FLIM: rd_addr = vfsm_pkg::ADDR_W'(n_c - 1'b1);
      vfsm_pkg::S_DIDX: rd_addr = vfsm_pkg::ADDR_W'(cnt_r - 1'b1);
      default: rd_addr = i_r[vfsm_pkg::ADDR_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && !in_func) begin
      bt_mem[in_entry_index] <= in_entry_value;
    end
    mem_q_r <= bt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vfsm_pkg::S_IDLE;
      fat16_r <= 1'b0;
      mbr_en_r <= 1'b0;
      spf_r <= 16'd8;
      total_r <= '0;
      serial_r <= '0;
      bcount_r <= '0;
      out_valid_r <= 1'b0;
      q_vld_r <= 1'b0;
      i_r <= '0;
      w_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          vfsm_pkg::REG_FAT16_MODE: fat16_r <= cfg_data[0];
          vfsm_pkg::REG_MBR_ENABLE: mbr_en_r <= cfg_data[0];
          vfsm_pkg::REG_SECTORS_PER_FAT: spf_r <= cfg_data[15:0];
          vfsm_pkg::REG_TOTAL_SECTORS: total_r <= cfg_data;
          vfsm_pkg::REG_VOLUME_SERIAL: serial_r <= cfg_data;
          vfsm_pkg::REG_BOUNDARY_COUNT: bcount_r <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      q_vld_r <= (state_r == vfsm_pkg::S_FSCAN || state_r == vfsm_pkg::S_DSCAN) &&
                 (i_r < n_c);
      if (state_r == vfsm_pkg::S_FLIMW || state_r == vfsm_pkg::S_DKEY) begin
        i_r <= '0;
      end else if ((state_r == vfsm_pkg::S_FSCAN || state_r == vfsm_pkg::S_DSCAN) &&
                   i_r < n_c) begin
        i_r <= i_r + 1'b1;
      end
      if (state_r == vfsm_pkg::S_IDLE) w_r <= '0;
      else if (state_r == vfsm_pkg::S_EMIT && out_free) w_r <= w_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      vfsm_pkg::S_IDLE: off_r <= in_lba;
      vfsm_pkg::S_MBR: begin
        gen_rgn_r <= vfsm_pkg::RGN_MBR;
        desc_rgn_r <= vfsm_pkg::RGN_ZERO;
        desc_sec_r <= '0;
        desc_fi_r <= '0;
        if (mbr_en_r && off_r >= 32'd8) off_r <= off_r - 32'd8;
      end
      vfsm_pkg::S_RES: begin
        desc_rgn_r <= vfsm_pkg::RGN_RESERVED;
        desc_sec_r <= off_r;
        off_r <= off_r - (fat16_r ? 32'd1 : 32'd16);
      end
      vfsm_pkg::S_FATD: begin
        gen_rgn_r <= vfsm_pkg::RGN_FAT;
        if (off_r < 32'(fat2_c)) begin
          if (off_r >= 32'(spf_r)) off_r <= off_r - 32'(spf_r);
        end else begin
          off_r <= off_r - 32'(fat2_c);
        end
      end
      vfsm_pkg::S_ROOT: begin
        desc_rgn_r <= vfsm_pkg::RGN_ROOT;
        desc_sec_r <= off_r;
        off_r <= off_r - 32'd32;
      end
      vfsm_pkg::S_FLIM: start_r <= fat16_r ? (off_r << 8) : (off_r << 7);
      vfsm_pkg::S_FLIMW: begin
        limit_r <= (n_c != '0) ? mem_q_r : 32'd2;
        start_p1_r <= start_r + 32'd1;
        bmp_r <= '0;
      end
      vfsm_pkg::S_FSCAN: begin
        if (q_vld_r && dist_c < 32'(per_c)) bmp_r[dist_c[7:0]] <= 1'b1;
      end
      vfsm_pkg::S_DKEY: begin
        key_r <= (off_r >> 3) + 32'd2;
        cnt_r <= '0;
      end
      vfsm_pkg::S_DSCAN: begin
        if (q_vld_r && mem_q_r <= key_r) cnt_r <= cnt_r + 1'b1;
        if (scan_done) begin
          desc_sec_r <= off_r;
          if (cnt_r >= n_c) begin
            desc_rgn_r <= vfsm_pkg::RGN_ZERO;
            desc_sec_r <= '0;
          end else if (cnt_r < files_c) begin
            desc_rgn_r <= vfsm_pkg::RGN_FILE;
            desc_fi_r <= 11'(cnt_r);
          end else begin
            desc_rgn_r <= vfsm_pkg::RGN_ROOT;
          end
        end
      end
      vfsm_pkg::S_DIDXW: desc_sec_r <= off_r - ((mem_q_r - 32'd2) << 3);
      default: ;
    endcase
    if (out_load) begin
      if (state_r == vfsm_pkg::S_EMIT) begin
        out_region_r <= gen_rgn_r;
        out_data_r <= word_c;
        out_fi_r <= '0;
        out_sec_r <= '0;
        out_last_r <= (w_r == 6'd63);
      end else begin
        out_region_r <= desc_rgn_r;
        out_data_r <= '0;
        out_fi_r <= desc_fi_r;
        out_sec_r <= desc_sec_r;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_region = out_region_r;
  assign out_data_word = out_data_r;
  assign out_file_index = out_fi_r;
  assign out_sector_in_region = out_sec_r;
  assign out_last = out_last_r;

  a_desc_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_region_r != vfsm_pkg::RGN_MBR &&
     out_region_r != vfsm_pkg::RGN_FAT) |-> out_last_r)
    else $error("descriptor result without last");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vfsm_pkg::S_EMIT && w_r != '0) |-> out_valid_r)
    else $error("word counter ran ahead of the output register");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vfsm_pkg::S_FSCAN || state_r == vfsm_pkg::S_DSCAN) |-> (i_r <= n_c))
    else $error("table scan passed the valid count");

  a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vfsm_pkg::S_EMIT && out_free && w_r == 6'd63) |=>
    (state_r == vfsm_pkg::S_IDLE && out_last_r))
    else $error("sector emission did not end with last");

endmodule

/* tb/virtual_fat_sector_mapper_core_tb.sv */
`timescale 1ns / 1ps
module virtual_fat_sector_mapper_core_tb;

  typedef struct {
    logic [2:0]  region;
    logic [63:0] data_word;
    logic [10:0] file_index;
    logic [31:0] sector;
    logic        last;
  } sector_word_t;

  typedef struct {
    logic        func;
    logic [31:0] lba;
    logic [9:0]  eidx;
    logic [31:0] eval;
    logic        has_exp;
    logic [2:0]  exp_region;
    logic [31:0] exp_sector;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [31:0] in_lba;
  logic [9:0]  in_entry_index;
  logic [31:0] in_entry_value;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_region;
  logic [63:0] out_data_word;
  logic [10:0] out_file_index;
  logic [31:0] out_sector_in_region;
  logic        out_last;

  virtual_fat_sector_mapper_core DUT (.*);

  logic [31:0] extent_end [vfsm_pkg::MAX_ENTRIES];
  logic        m_fat16, m_mbr;
  logic [15:0] m_spf;
  logic [31:0] m_total, m_serial;
  logic [10:0] m_count;

  sector_word_t pending_words[$];
  int errors;
  int cycles;
  bit stim_done;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 5000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int unsigned live_count();
    return (m_count > vfsm_pkg::MAX_ENTRIES) ? vfsm_pkg::MAX_ENTRIES : m_count;
  endfunction

  task automatic push_word(input logic [2:0] r, input logic [63:0] d,
                           input logic [10:0] f, input logic [31:0] s, input logic l);
    sector_word_t w;
    w.region = r; w.data_word = d; w.file_index = f; w.sector = s; w.last = l;
    pending_words = {pending_words, w};
  endtask

  task automatic push_sector(input logic [7:0] buf_b [512], input logic [2:0] r);
    logic [63:0] v;
    for (int w = 0; w < 64; w++) begin
      for (int b = 0; b < 8; b++) v[8*b +: 8] = buf_b[w*8+b];
      push_word(r, v, '0, '0, w == 63);
    end
  endtask

  task automatic predict_read(input logic [31:0] lba);
    logic [7:0]  sb [512];
    logic [31:0] off, nres, fat2, start, lim, c, link, fi, files, key, tv;
    int unsigned n, per;
    bit hit;
    n = live_count();
    off = lba;
    tv = m_total - 32'd8;
    for (int i = 0; i < 512; i++) sb[i] = 8'h00;
    if (m_mbr) begin
      if (off < 32'd8) begin
        if (off != 0) begin
          push_word(vfsm_pkg::RGN_ZERO, '0, '0, '0, 1'b1);
          return;
        end
        for (int i = 0; i < 4; i++) begin
          sb[12'h1B8+i] = m_serial[8*i +: 8];
          sb[12'h1C0+i] = vfsm_pkg::CHS_START[8*i +: 8];
          sb[12'h1C6+i] = (i == 0) ? 8'd8 : 8'd0;
          sb[12'h1CA+i] = tv[8*i +: 8];
        end
        sb[12'h1BE] = vfsm_pkg::BOOT_FLAG;
        sb[12'h1C2] = m_fat16 ? vfsm_pkg::PART_FAT16 : vfsm_pkg::PART_FAT32;
        sb[12'h1C3] = 8'hFE;
        sb[12'h1C4] = 8'hFF;
        sb[12'h1C5] = 8'hFF;
        sb[12'h1FE] = vfsm_pkg::SIG_LO;
        sb[12'h1FF] = vfsm_pkg::SIG_HI;
        push_sector(sb, vfsm_pkg::RGN_MBR);
        return;
      end
      off -= 32'd8;
    end
    nres = m_fat16 ? 32'd1 : 32'd16;
    if (off < nres) begin
      push_word(vfsm_pkg::RGN_RESERVED, '0, '0, off, 1'b1);
      return;
    end
    off -= nres;
    fat2 = {15'd0, m_spf, 1'b0};
    if (off < fat2) begin
      if (off >= {16'd0, m_spf}) off -= {16'd0, m_spf};
      start = m_fat16 ? off << 8 : off << 7;
      per = m_fat16 ? 256 : 128;
      lim = (n != 0) ? extent_end[n-1] : 32'd2;
      for (int i = 0; i < per; i++) begin
        c = start + 32'(i);
        hit = 0;
        for (int k = 0; k < n; k++) if (extent_end[k] == c + 32'd1) hit = 1;
        if (c >= lim) link = '0;
        else if (hit) link = m_fat16 ? {16'h0, vfsm_pkg::EOC16} : vfsm_pkg::EOC32;
        else link = c + 32'd1;
        if (m_fat16) begin
          sb[2*i] = link[7:0]; sb[2*i+1] = link[15:8];
        end else begin
          for (int b = 0; b < 4; b++) sb[4*i+b] = link[8*b +: 8];
        end
      end
      if (off == 0) begin
        sb[0] = vfsm_pkg::MEDIA_BYTE; sb[1] = 8'hFF; sb[2] = 8'hFF; sb[3] = 8'hFF;
        if (!m_fat16) for (int b = 4; b < 8; b++) sb[b] = 8'hFF;
      end
      push_sector(sb, vfsm_pkg::RGN_FAT);
      return;
    end
    off -= fat2;
    if (m_fat16) begin
      if (off < 32'd32) begin
        push_word(vfsm_pkg::RGN_ROOT, '0, '0, off, 1'b1);
        return;
      end
      off -= 32'd32;
    end
    key = (off >> 3) + 32'd2;
    fi = '0;
    for (int k = 0; k < n; k++) if (extent_end[k] <= key) fi++;
    files = m_fat16 ? 32'(n) : ((n != 0) ? 32'(n - 1) : 32'd0);
    if (fi < n) begin
      if (fi != 0) off -= (extent_end[fi-1] - 32'd2) * 32'd8;
      if (fi < files) push_word(vfsm_pkg::RGN_FILE, '0, fi[10:0], off, 1'b1);
      else push_word(vfsm_pkg::RGN_ROOT, '0, '0, off, 1'b1);
      return;
    end
    push_word(vfsm_pkg::RGN_ZERO, '0, '0, '0, 1'b1);
  endtask

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    repeat (g) @(negedge clk);
  endtask

  task automatic send_item(input logic f, input logic [31:0] lba, input logic [9:0] ei,
                           input logic [31:0] ev, input logic he, input logic [2:0] er,
                           input logic [31:0] es);
    @(negedge clk);
    in_valid = 1; in_func = f; in_lba = lba; in_entry_index = ei; in_entry_value = ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (f && he) push_word(er, '0, '0, es, 1'b1);
    else if (f) predict_read(lba);
    else extent_end[ei] = ev;
    @(negedge clk);
    in_valid = 0;
    idle_gap();
  endtask

  task automatic send(input logic f, input logic [31:0] lba, input logic [9:0] ei,
                      input logic [31:0] ev);
    send_item(f, lba, ei, ev, 1'b0, vfsm_pkg::RGN_ZERO, '0);
  endtask

  task automatic drain();
    while (pending_words.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    @(negedge clk);
    cfg_we = 1; cfg_index = idx; cfg_data = v;
    case (idx)
      vfsm_pkg::REG_FAT16_MODE: m_fat16 = v[0];
      vfsm_pkg::REG_MBR_ENABLE: m_mbr = v[0];
      vfsm_pkg::REG_SECTORS_PER_FAT: m_spf = v[15:0];
      vfsm_pkg::REG_TOTAL_SECTORS: m_total = v;
      vfsm_pkg::REG_VOLUME_SERIAL: m_serial = v;
      vfsm_pkg::REG_BOUNDARY_COUNT: m_count = v[10:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 0;
  endtask

  // A sorted extent table with small gaps, occasionally with zero-length files.
  task automatic load_table(input int unsigned cnt);
    logic [31:0] v;
    v = 2;
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 5) != 0) v += $urandom_range(1, 40);
      send(1'b0, $urandom, i[9:0], v);
    end
  endtask

  function automatic logic [31:0] data_start();
    return 32'((m_mbr ? 8 : 0) + (m_fat16 ? 33 : 16) + 2 * m_spf);
  endfunction

  always @(posedge clk) begin
    sector_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0)
        report_mismatch("unexpected result", 64'(out_region), '0);
      else begin
        w = pending_words.pop_front();
        if (out_region !== w.region)
          report_mismatch("region", 64'(out_region), 64'(w.region));
        if (out_data_word !== w.data_word) report_mismatch("data", out_data_word, w.data_word);
        if (out_file_index !== w.file_index)
          report_mismatch("file_index", 64'(out_file_index), 64'(w.file_index));
        if (out_sector_in_region !== w.sector)
          report_mismatch("sector", 64'(out_sector_in_region), 64'(w.sector));
        if (out_last !== w.last) report_mismatch("last", 64'(out_last), 64'(w.last));
      end
    end
  end

  initial begin
    int g;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (stim_done) out_stall = 0;
      else if ($urandom_range(0, 3) == 0) begin
        g = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
        out_stall = 1;
        repeat (g - 1) @(negedge clk);
        @(negedge clk);
        out_stall = 0;
      end
    end
  end

  dir_row_t rows[$];

  task automatic add_row(input logic f, input logic [31:0] lba, input logic [9:0] ei,
                         input logic [31:0] ev, input logic he, input logic [2:0] r,
                         input logic [31:0] s);
    dir_row_t d;
    d.func = f; d.lba = lba; d.eidx = ei; d.eval = ev;
    d.has_exp = he; d.exp_region = r; d.exp_sector = s;
    rows = {rows, d};
  endtask

  initial begin
    logic [31:0] ds, lba;
    int unsigned nb;
    errors = 0; cycles = 0; stim_done = 0;
    rst_n = 0; cfg_we = 0; cfg_index = vfsm_pkg::REG_FAT16_MODE; cfg_data = 0;
    in_valid = 0; in_func = 0; in_lba = 0; in_entry_index = 0; in_entry_value = 0;
    m_fat16 = 0; m_mbr = 0; m_spf = 8; m_total = 0; m_serial = 0; m_count = 0;
    for (int i = 0; i < vfsm_pkg::MAX_ENTRIES; i++) extent_end[i] = 0;
    repeat (10) @(negedge clk);
    rst_n = 1;

    // After reset: FAT32, no MBR, 8 sectors per FAT, empty table.
    add_row(1'b1, 32'd0, '0, '0, 1'b1, vfsm_pkg::RGN_RESERVED, 32'd0);
    add_row(1'b1, 32'd15, '0, '0, 1'b1, vfsm_pkg::RGN_RESERVED, 32'd15);
    add_row(1'b1, 32'd16, '0, '0, 1'b0, vfsm_pkg::RGN_ZERO, '0);
    add_row(1'b1, 32'd31, '0, '0, 1'b0, vfsm_pkg::RGN_ZERO, '0);
    add_row(1'b1, 32'd32, '0, '0, 1'b1, vfsm_pkg::RGN_ZERO, '0);
    add_row(1'b1, 32'hFFFF_FFFF, '0, '0, 1'b1, vfsm_pkg::RGN_ZERO, '0);
    add_row(1'b0, '0, 10'd0, 32'd5, 1'b0, vfsm_pkg::RGN_ZERO, '0);
    add_row(1'b0, '0, 10'd1, 32'd5, 1'b0, vfsm_pkg::RGN_ZERO, '0);
    add_row(1'b0, '0, 10'd2, 32'd9, 1'b0, vfsm_pkg::RGN_ZERO, '0);
    add_row(1'b0, '0, 10'd1023, 32'hFFFF_FFFF, 1'b0, vfsm_pkg::RGN_ZERO, '0);
    foreach (rows[i])
      send_item(rows[i].func, rows[i].lba, rows[i].eidx, rows[i].eval,
                rows[i].has_exp, rows[i].exp_region, rows[i].exp_sector);
    drain();
    write_reg(vfsm_pkg::REG_BOUNDARY_COUNT, 32'd3);
    write_reg(vfsm_pkg::REG_TOTAL_SECTORS, 32'hFFFF_FFFF);
    write_reg(vfsm_pkg::REG_VOLUME_SERIAL, 32'hA5C3_0F71);
    write_reg(vfsm_pkg::REG_MBR_ENABLE, 32'd1);
    for (int l = 0; l < 8; l++) send(1'b1, l, '0, '0);
    for (int l = 24; l < 80; l += 3) send(1'b1, l, '0, '0);
    send(1'b1, 32'd32, '0, '0);
    drain();
    write_reg(vfsm_pkg::REG_FAT16_MODE, 32'd1);
    write_reg(vfsm_pkg::REG_TOTAL_SECTORS, 32'd0);
    write_reg(vfsm_pkg::REG_SECTORS_PER_FAT, 32'd0);
    for (int l = 0; l < 70; l += 2) send(1'b1, l, '0, '0);
    drain();

    // Random phases with fresh tables and settings.
    for (int ph = 0; ph < 10; ph++) begin
      nb = $urandom_range(1, 20);
      write_reg(vfsm_pkg::REG_FAT16_MODE, $urandom_range(0, 1));
      write_reg(vfsm_pkg::REG_MBR_ENABLE, $urandom_range(0, 1));
      write_reg(vfsm_pkg::REG_SECTORS_PER_FAT, (ph == 3) ? 32'hFFFF : $urandom_range(8, 40));
      write_reg(vfsm_pkg::REG_TOTAL_SECTORS, $urandom);
      write_reg(vfsm_pkg::REG_VOLUME_SERIAL, $urandom);
      load_table(nb);
      write_reg(vfsm_pkg::REG_BOUNDARY_COUNT, nb);
      ds = data_start();
      for (int i = 0; i < 35; i++) begin
        case ($urandom_range(0, 5))
          0: lba = $urandom_range(0, 24);
          1: lba = (m_mbr ? 8 : 0) + (m_fat16 ? 1 : 16) + $urandom_range(0, 2 * m_spf);
          2, 3: lba = ds + $urandom_range(0, 8 * extent_end[live_count() - 1] + 40);
          4: lba = $urandom;
          default: lba = ds - $urandom_range(0, 40);
        endcase
        if ($urandom_range(0, 7) == 0)
          send(1'b0, $urandom, 10'($urandom_range(nb, 1023)), $urandom);
        else send(1'b1, lba, '0, '0);
      end
      drain();
    end
    stim_done = 1;
    drain();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* virtual_fat_sector_mapper_core.f */
rtl/vfsm_pkg.sv
rtl/virtual_fat_sector_mapper_core.sv
tb/virtual_fat_sector_mapper_core_tb.sv
